/* rtl/gllq2d_pkg.sv */
// Package for the 2D Gauss-Lobatto element quadrature core: item type,
// register codes, queue sizing and the one-dimensional weight tables.
// No dependencies; every other file of the block but the checker uses it.
package gllq2d_pkg;

    // Default sizing for the top-level parameters
    localparam int unsigned DEF_MAX_COMPONENTS = 16;
    localparam int unsigned DEF_MAX_ORDER      = 10;

    // Field and register widths
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned ORDER_W = 4;
    localparam int unsigned COMP_W  = 5;
    localparam int unsigned ELEM_W  = 21;
    localparam int unsigned NODE_W  = 4;
    localparam int unsigned CIDX_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 21;

    // Weight table layout: one row of TBL_SIDE entries per order, order 2 first
    localparam int unsigned TBL_SIDE = 11;
    localparam int unsigned WQ_W     = 31;   // Q1.30 one-dimensional weight
    localparam int unsigned WP_W     = 24;   // Q2.22 weight product
    localparam logic [63:0] WSCALE   = 64'd10000000000000;

    // Queue between the front and the back
    localparam int unsigned QDEPTH = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY_ORDER  = 2'd0,
        CFG_COMP_COUNT  = 2'd1,
        CFG_ELEM_COUNT  = 2'd2
    } t_cfg_reg;

    // One classified item as it travels from the front to the back
    typedef struct packed {
        logic signed [VAL_W-1:0]  nodal_value;
        logic signed [VAL_W-1:0]  prior_total;
        logic [COMP_W-1:0]        comp;
        logic [ORDER_W-1:0]       order;
        logic [NODE_W-1:0]        node_i;
        logic [NODE_W-1:0]        node_j;
        logic                     is_first;
        logic                     is_final;
        logic                     last_grid;
    } t_item;

    // One-dimensional GLL weights in units of 1e-13, row (order-2), column k
    function automatic logic [63:0] w1e13(input logic [6:0] idx);
        logic [63:0] w;
        unique case (idx)
            7'd0, 7'd2:                w = 64'd3333333333330;
            7'd1:                      w = 64'd13333333333300;
            7'd11, 7'd14:              w = 64'd1666666666670;
            7'd12, 7'd13:              w = 64'd8333333333330;
            7'd22, 7'd26:              w = 64'd1000000000000;
            7'd23, 7'd25:              w = 64'd5444444444440;
            7'd24:                     w = 64'd7111111111110;
            7'd33, 7'd38:              w = 64'd666666666667;
            7'd34, 7'd37:              w = 64'd3784749562980;
            7'd35, 7'd36:              w = 64'd5548583770350;
            7'd44, 7'd50:              w = 64'd476190476190;
            7'd45, 7'd49:              w = 64'd2768260473620;
            7'd46, 7'd48:              w = 64'd4317453812100;
            7'd47:                     w = 64'd4876190476190;
            7'd55, 7'd62:              w = 64'd357142857143;
            7'd56, 7'd61:              w = 64'd2107042271440;
            7'd57, 7'd60:              w = 64'd3411226924840;
            7'd58, 7'd59:              w = 64'd4124587946590;
            7'd66, 7'd74:              w = 64'd277777777778;
            7'd67, 7'd73:              w = 64'd1654953615610;
            7'd68, 7'd72:              w = 64'd2745387125000;
            7'd69, 7'd71:              w = 64'd3464285109730;
            7'd70:                     w = 64'd3715192743760;
            7'd77, 7'd86:              w = 64'd222222222222;
            7'd78, 7'd85:              w = 64'd1333059908510;
            7'd79, 7'd84:              w = 64'd2248893420630;
            7'd80, 7'd83:              w = 64'd2920426836800;
            7'd81, 7'd82:              w = 64'd3275397611840;
            7'd88, 7'd98:              w = 64'd181818181818;
            7'd89, 7'd97:              w = 64'd1096122732670;
            7'd90, 7'd96:              w = 64'd1871698817800;
            7'd91, 7'd95:              w = 64'd2480481042640;
            7'd92, 7'd94:              w = 64'd2868791247790;
            7'd93:                     w = 64'd3002175954560;
            default:                   w = 64'd0;
        endcase
        return w;
    endfunction

    // Convert a 1e-13 weight to Q1.30 with round half up, 15 bits a step
    function automatic logic [WQ_W-1:0] weight_q30(input logic [63:0] a);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] s;
        q = a / WSCALE;
        r = a % WSCALE;
        for (int k = 0; k < 2; k++) begin
            s = r << 15;
            q = (q << 15) + s / WSCALE;
            r = s % WSCALE;
        end
        if ((r << 1) >= WSCALE) begin
            q = q + 64'd1;
        end
        return q[WQ_W-1:0];
    endfunction

endpackage

/* rtl/gllq2d_if.sv */
// Channel interfaces of the quadrature core: nodal input, result output
// and configuration write. Uses gllq2d_pkg for widths.
interface gllq2d_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [gllq2d_pkg::VAL_W-1:0]   nodal_value;
    logic signed [gllq2d_pkg::VAL_W-1:0]   prior_total;

    modport source (output valid, nodal_value, prior_total, input ready);
    modport sink   (input valid, nodal_value, prior_total, output ready);
endinterface

interface gllq2d_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [gllq2d_pkg::VAL_W-1:0]   new_total;
    logic [gllq2d_pkg::CIDX_W-1:0]         component_index;
    logic                                  saturated;
    logic                                  last_of_grid;

    modport source (output valid, new_total, component_index, saturated, last_of_grid,
                    input ready);
    modport sink   (input valid, new_total, component_index, saturated, last_of_grid,
                    output ready);
endinterface

interface gllq2d_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [gllq2d_pkg::CFG_IDX_W-1:0]      index;
    logic [gllq2d_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/gll_element_quadrature_2d_core.sv */
// Top level of the 2D Gauss-Lobatto element quadrature core.
// Depends on gllq2d_pkg, gllq2d_if, gllq2d_front, gllq2d_queue, gllq2d_back.
//
// Usage:
//   i_in  : nodal values (Q15.16) in element order, component fastest, then
//           node column j, then node row i. prior_total matters only on the
//           last node of an element.
//   o_out : one result per component at the last node of each element:
//           prior_total plus the weighted element sum divided by 4, rounded
//           to Q15.16 and clipped; saturated flags a clip, last_of_grid marks
//           the last component of the last element.
//   i_cfg : register writes (poly order, component count, element count);
//           any write to a known register restarts traversal at element 0.
//           Write only while the block is idle.
// Throughput: one value per cycle while the receiver takes results. From the
//   input transfer to the result come the queue write, weight lookup, weight
//   product, multiply, accumulate, round and the output register.
// Reset: registers go to order 2, one component, one element; counters and
//   the queue clear. When the receiver stalls, the back holds and the queue
//   of four items fills before i_in.ready drops.
module gll_element_quadrature_2d_core #(
    parameter int unsigned MAX_COMPONENTS = gllq2d_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned MAX_ORDER      = gllq2d_pkg::DEF_MAX_ORDER
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gllq2d_in_if.sink     i_in,
    gllq2d_cfg_if.sink    i_cfg,
    gllq2d_out_if.source  o_out
);

    logic              push_valid;
    logic              push_ready;
    gllq2d_pkg::t_item push_item;
    logic              pop_valid;
    logic              pop;
    gllq2d_pkg::t_item pop_item;

    // Accept and classify
    gllq2d_front #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .MAX_ORDER      (MAX_ORDER)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    // Decouple front and back
    gllq2d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_item   (pop_item)
    );

    // Weight, accumulate and deliver
    gllq2d_back #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .MAX_ORDER      (MAX_ORDER)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .i_q_item  (pop_item),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

endmodule

/* rtl/gllq2d_front.sv */
// Front of the quadrature core: configuration registers, node and element
// traversal counters, and classification of each accepted value.
// Depends on gllq2d_pkg and gllq2d_if.
module gllq2d_front #(
    parameter int unsigned MAX_COMPONENTS = gllq2d_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned MAX_ORDER      = gllq2d_pkg::DEF_MAX_ORDER
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gllq2d_in_if.sink             i_in,
    gllq2d_cfg_if.sink            i_cfg,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output gllq2d_pkg::t_item     o_push_item
);

    logic [gllq2d_pkg::ORDER_W-1:0] r_poly_order, n_poly_order;
    logic [gllq2d_pkg::COMP_W-1:0]  r_comp_count, n_comp_count;
    logic [gllq2d_pkg::ELEM_W-1:0]  r_elem_count, n_elem_count;
    logic [gllq2d_pkg::COMP_W-1:0]  r_comp, n_comp;
    logic [gllq2d_pkg::NODE_W-1:0]  r_node_i, n_node_i;
    logic [gllq2d_pkg::NODE_W-1:0]  r_node_j, n_node_j;
    logic [gllq2d_pkg::ELEM_W-1:0]  r_elem, n_elem;

    logic [gllq2d_pkg::ORDER_W-1:0] eff_order;
    logic [gllq2d_pkg::COMP_W-1:0]  eff_comps;
    logic [gllq2d_pkg::ELEM_W-1:0]  eff_elems;
    logic                           last_comp;
    logic                           last_i;
    logic                           last_j;
    logic                           last_elem;
    logic                           accept;

    // Clamp the registers to their working ranges
    always_comb begin
        if (r_poly_order < 4'd2) begin
            eff_order = 4'd2;
        end else if (r_poly_order > gllq2d_pkg::ORDER_W'(MAX_ORDER)) begin
            eff_order = gllq2d_pkg::ORDER_W'(MAX_ORDER);
        end else begin
            eff_order = r_poly_order;
        end
        if (r_comp_count == '0) begin
            eff_comps = 5'd1;
        end else if (7'(r_comp_count) > 7'(MAX_COMPONENTS)) begin
            eff_comps = gllq2d_pkg::COMP_W'(MAX_COMPONENTS);
        end else begin
            eff_comps = r_comp_count;
        end
        eff_elems = (r_elem_count == '0) ? 21'd1 : r_elem_count;
    end

    // Classify the current position
    assign last_comp = ({1'b0, r_comp} + 6'd1) >= {1'b0, eff_comps};
    assign last_i    = (r_node_i == eff_order);
    assign last_j    = (r_node_j == eff_order);
    assign last_elem = ({1'b0, r_elem} + 22'd1) >= {1'b0, eff_elems};

    assign accept       = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_push_valid = i_in.valid;

    always_comb begin
        o_push_item.nodal_value = i_in.nodal_value;
        o_push_item.prior_total = i_in.prior_total;
        o_push_item.comp        = r_comp;
        o_push_item.order       = eff_order;
        o_push_item.node_i      = r_node_i;
        o_push_item.node_j      = r_node_j;
        o_push_item.is_first    = (r_node_i == '0) && (r_node_j == '0);
        o_push_item.is_final    = last_i && last_j;
        o_push_item.last_grid   = last_comp && last_elem;
    end

    // Advance the traversal on a transfer; a register write restarts it
    always_comb begin
        n_poly_order = r_poly_order;
        n_comp_count = r_comp_count;
        n_elem_count = r_elem_count;
        n_comp       = r_comp;
        n_node_i     = r_node_i;
        n_node_j     = r_node_j;
        n_elem       = r_elem;
        if (accept) begin
            if (!last_comp) begin
                n_comp = r_comp + 5'd1;
            end else begin
                n_comp = '0;
                if (!last_j) begin
                    n_node_j = r_node_j + 4'd1;
                end else begin
                    n_node_j = '0;
                    if (!last_i) begin
                        n_node_i = r_node_i + 4'd1;
                    end else begin
                        n_node_i = '0;
                        n_elem   = last_elem ? '0 : r_elem + 21'd1;
                    end
                end
            end
        end
        if (i_cfg.valid) begin
            unique case (gllq2d_pkg::t_cfg_reg'(i_cfg.index))
                gllq2d_pkg::CFG_POLY_ORDER: begin
                    n_poly_order = i_cfg.data[gllq2d_pkg::ORDER_W-1:0];
                end
                gllq2d_pkg::CFG_COMP_COUNT: begin
                    n_comp_count = i_cfg.data[gllq2d_pkg::COMP_W-1:0];
                end
                gllq2d_pkg::CFG_ELEM_COUNT: begin
                    n_elem_count = i_cfg.data[gllq2d_pkg::ELEM_W-1:0];
                end
                default: begin
                end
            endcase
            if (i_cfg.index == gllq2d_pkg::CFG_POLY_ORDER ||
                i_cfg.index == gllq2d_pkg::CFG_COMP_COUNT ||
                i_cfg.index == gllq2d_pkg::CFG_ELEM_COUNT) begin
                n_comp   = '0;
                n_node_i = '0;
                n_node_j = '0;
                n_elem   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_order <= 4'd2;
            r_comp_count <= 5'd1;
            r_elem_count <= 21'd1;
            r_comp       <= '0;
            r_node_i     <= '0;
            r_node_j     <= '0;
            r_elem       <= '0;
        end else begin
            r_poly_order <= n_poly_order;
            r_comp_count <= n_comp_count;
            r_elem_count <= n_elem_count;
            r_comp       <= n_comp;
            r_node_i     <= n_node_i;
            r_node_j     <= n_node_j;
            r_elem       <= n_elem;
        end
    end

endmodule

/* rtl/gllq2d_queue.sv */
// Short queue between the front and the back of the quadrature core.
// Holds classified items; depends on gllq2d_pkg.
module gllq2d_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    output logic                  o_push_ready,
    input  gllq2d_pkg::t_item     i_push_item,
    output logic                  o_pop_valid,
    input  logic                  i_pop,
    output gllq2d_pkg::t_item     o_pop_item
);

    localparam int unsigned QPW = $clog2(gllq2d_pkg::QDEPTH);
    localparam int unsigned QCW = $clog2(gllq2d_pkg::QDEPTH + 1);

    gllq2d_pkg::t_item r_mem [gllq2d_pkg::QDEPTH];
    logic [QPW-1:0]    r_wr, r_rd;
    logic [QCW-1:0]    r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCW'(gllq2d_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

/* rtl/gllq2d_back.sv */
// Back of the quadrature core: weight lookup, weight product, multiply,
// per-component accumulation, rounding, saturation and the result register.
// Depends on gllq2d_pkg and gllq2d_if.
module gllq2d_back #(
    parameter int unsigned MAX_COMPONENTS = gllq2d_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned MAX_ORDER      = gllq2d_pkg::DEF_MAX_ORDER
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  gllq2d_pkg::t_item     i_q_item,
    output logic                  o_q_pop,
    gllq2d_out_if.source          o_out
);

    localparam int unsigned ROM_N = (MAX_ORDER - 1) * gllq2d_pkg::TBL_SIDE;
    localparam int unsigned RIW   = (ROM_N > 1) ? $clog2(ROM_N) : 1;
    localparam int unsigned CIW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int unsigned WQ_W  = gllq2d_pkg::WQ_W;
    localparam int unsigned WP_W  = gllq2d_pkg::WP_W;
    localparam int unsigned TERM_W = gllq2d_pkg::VAL_W + WP_W + 1;

    // Q1.30 weights, worked out at elaboration
    logic [WQ_W-1:0] w_rom [ROM_N];
    for (genvar g = 0; g < ROM_N; g++) begin : g_wrom
        localparam logic [WQ_W-1:0] WQ = gllq2d_pkg::weight_q30(gllq2d_pkg::w1e13(7'(g)));
        assign w_rom[g] = WQ;
    end

    logic adv;

    logic                        r_s1_valid;
    gllq2d_pkg::t_item           r_s1_item;
    logic [WQ_W-1:0]             r_s1_wi, r_s1_wj;
    logic                        r_s2_valid;
    gllq2d_pkg::t_item           r_s2_item;
    logic [WP_W-1:0]             r_s2_wp;
    logic                        r_s3_valid;
    gllq2d_pkg::t_item           r_s3_item;
    logic signed [TERM_W-1:0]    r_s3_term;
    logic                        r_s4_valid;
    gllq2d_pkg::t_item           r_s4_item;
    logic [63:0]                 r_s4_acc;
    logic                        r_s5_valid;
    gllq2d_pkg::t_item           r_s5_item;
    logic signed [40:0]          r_s5_rnd;
    logic [63:0]                 r_acc [MAX_COMPONENTS];

    logic                        r_o_valid;
    logic signed [31:0]          r_o_total;
    logic [gllq2d_pkg::CIDX_W-1:0] r_o_comp;
    logic                        r_o_sat;
    logic                        r_o_last;

    logic [6:0]                  row_base;
    logic [RIW-1:0]              idx_i, idx_j;
    logic [2*WQ_W-1:0]           prod_ww;
    logic [2*WQ_W-1:0]           prod_rnd;
    logic signed [TERM_W-1:0]    term;
    logic [CIW-1:0]              acc_idx;
    logic [63:0]                 n_acc;
    logic signed [40:0]          rnd;
    logic signed [41:0]          sum;
    logic                        sat_hi, sat_lo;
    logic signed [31:0]          n_total;

    // The whole back advances together unless a result waits untaken
    assign adv     = !r_o_valid || o_out.ready;
    assign o_q_pop = adv && i_q_valid;

    // Look up both one-dimensional weights for the head item
    assign row_base = ({3'b0, i_q_item.order} - 7'd2) * 7'd11;
    assign idx_i    = RIW'(row_base + {3'b0, i_q_item.node_i});
    assign idx_j    = RIW'(row_base + {3'b0, i_q_item.node_j});

    // Weight product, rounded to Q2.22
    assign prod_ww  = r_s1_wi * r_s1_wj;
    assign prod_rnd = prod_ww + ((2*WQ_W)'(1) << 37);

    // Value times weight product
    assign term = $signed(r_s2_item.nodal_value) * $signed({1'b0, r_s2_wp});

    // Replace at element start, otherwise add
    assign acc_idx = CIW'(r_s3_item.comp);
    always_comb begin
        if (r_s3_item.is_first) begin
            n_acc = {{(64-TERM_W){r_s3_term[TERM_W-1]}}, r_s3_term};
        end else begin
            n_acc = r_acc[acc_idx] + {{(64-TERM_W){r_s3_term[TERM_W-1]}}, r_s3_term};
        end
    end

    // Divide by 2^24 with halves rounded up
    assign rnd = $signed({r_s4_acc[63], r_s4_acc[63:24]}) + $signed({40'b0, r_s4_acc[23]});

    // Add the prior total and clip to 32 bits
    assign sum    = {r_s5_rnd[40], r_s5_rnd} +
                    {{10{r_s5_item.prior_total[31]}}, r_s5_item.prior_total};
    assign sat_hi = !sum[41] && (sum[41:31] != 11'h000);
    assign sat_lo = sum[41] && (sum[41:31] != 11'h7ff);
    always_comb begin
        if (sat_hi) begin
            n_total = 32'sh7fffffff;
        end else if (sat_lo) begin
            n_total = 32'sh80000000;
        end else begin
            n_total = sum[31:0];
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_item <= i_q_item;
            r_s1_wi   <= w_rom[idx_i];
            r_s1_wj   <= w_rom[idx_j];
            r_s2_item <= r_s1_item;
            r_s2_wp   <= prod_rnd[2*WQ_W-1:38];
            r_s3_item <= r_s2_item;
            r_s3_term <= term;
            r_s4_item <= r_s3_item;
            r_s4_acc  <= n_acc;
            r_s5_item <= r_s4_item;
            r_s5_rnd  <= rnd;
            if (r_s5_valid && r_s5_item.is_final) begin
                r_o_total <= n_total;
                r_o_comp  <= gllq2d_pkg::CIDX_W'(r_s5_item.comp);
                r_o_sat   <= sat_hi || sat_lo;
                r_o_last  <= r_s5_item.last_grid;
            end
            if (r_s3_valid) begin
                r_acc[acc_idx] <= n_acc;
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_o_valid  <= r_s5_valid && r_s5_item.is_final;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.new_total       = r_o_total;
    assign o_out.component_index = r_o_comp;
    assign o_out.saturated       = r_o_sat;
    assign o_out.last_of_grid    = r_o_last;

endmodule

/* rtl/gllq2d_checker.sv */
// Port-level checks for the quadrature core and the bind that attaches them.
// Depends on gll_element_quadrature_2d_core and gllq2d_if.
module gllq2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_total,
    input logic [3:0]  out_comp,
    input logic        out_sat,
    input logic        out_last
);

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // Queue is empty after reset, so input is taken
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> in_ready)
        else $error("input not ready after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_total) && $stable(out_comp) &&
            $stable(out_sat) && $stable(out_last))
        else $error("stalled result changed");

    // A clipped total sits at one of the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_sat |-> out_total == 32'h7fffffff || out_total == 32'h80000000)
        else $error("saturated flag without a limit value");

endmodule

bind gll_element_quadrature_2d_core gllq2d_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_total (o_out.new_total),
    .out_comp  (o_out.component_index),
    .out_sat   (o_out.saturated),
    .out_last  (o_out.last_of_grid)
);
